FILE: hw/rtl/aho_corasick_multi_pattern_matcher_macros.svh
// Assertion macros shared by the checker of the Aho-Corasick matcher.
// Each macro expands to one labeled concurrent assertion on clk, off in reset.
`ifndef AHO_CORASICK_MULTI_PATTERN_MATCHER_MACROS_SVH
`define AHO_CORASICK_MULTI_PATTERN_MATCHER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ACM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, once seen, requires another one at the next edge.
`define ACM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/acm_pkg.sv
// Shared types and codes of the Aho-Corasick matcher.
// Used by the controller, the datapath and the top level; depends on nothing.
package acm_pkg;

  // Sizes of the automaton; the port widths of the top level are fixed and do not follow these.
  localparam int NODES    = 1024;
  localparam int ALPHABET = 26;
  localparam int PATTERNS = 16;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_BUILD  = 2'd1;
  localparam logic [1:0] REQ_SCAN   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Result status codes carried on the output tuser.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // Datapath operations, one per controller step.
  typedef enum logic [4:0] {
    OP_IDLE, OP_LATCH, OP_ROOT_CLR,
    OP_INS_RD, OP_INS_CHK, OP_INS_MASK, OP_INS_ROW,
    OP_B_START, OP_B_RRD, OP_B_RCHK, OP_B_POP, OP_B_ID, OP_B_F, OP_B_MF, OP_B_MI,
    OP_B_E1, OP_B_E2, OP_B_E3,
    OP_SC_RD, OP_SC_CHK, OP_SC_MK
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic built;    // links have been built
    logic ch_zero;  // goto read data is the root
    logic full;     // node table is full
    logic last;     // latched request ends a pattern
    logic c_last;   // letter counter at its last letter
    logic q_more;   // breadth-first queue not empty
  } dp_stat_t;

endpackage

FILE: hw/rtl/acm_datapath.sv
// Datapath of the Aho-Corasick matcher: trie memories, queue, positions, results.
// Depends on acm_pkg; driven one operation per cycle by acm_controller.
module acm_datapath import acm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [4:0]          letter,
  input  logic                last_letter,
  input  logic [3:0]          pattern_index,
  input  logic                restart,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic [PATTERNS-1:0] res_mask,
  output logic [$clog2(NODES)-1:0] res_node,
  output logic [1:0]          res_status
);

  localparam int NW = $clog2(NODES);
  localparam int KW = NW + 1;
  localparam int CW = $clog2(ALPHABET);
  localparam int PW = PATTERNS;
  localparam int GD = NODES * ALPHABET;
  localparam int GW = $clog2(GD);

  // Memories and their registered read data.
  logic [NW-1:0] goto_mem [GD];
  logic [NW-1:0] fail_mem [NODES];
  logic [PW-1:0] mask_mem [NODES];
  logic [NW-1:0] queue_mem [NODES];
  logic [NW-1:0] goto_rd_r, fail_rd_r, queue_rd_r;
  logic [PW-1:0] mask_rd_r;

  logic          g_we, f_we, m_we, q_we;
  logic [GW-1:0] g_addr;
  logic [NW-1:0] g_wd, f_addr, f_wd, m_addr, q_addr, q_wd;
  logic [PW-1:0] m_wd;

  // Registers.
  logic [CW-1:0] letter_r, letter_nxt, c_r, c_nxt;
  logic          last_r, last_nxt, restart_r, restart_nxt, built_r, built_nxt;
  logic [PW-1:0] pbit_r, pbit_nxt, tmp_r, tmp_nxt, res_mask_r, res_mask_nxt;
  logic [KW-1:0] count_r, count_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [NW-1:0] pos_r, pos_nxt, scan_r, scan_nxt, id_r, id_nxt, f_r, f_nxt;
  logic [NW-1:0] cur_r, cur_nxt, res_node_r, res_node_nxt;
  logic [1:0]    res_status_r, res_status_nxt;

  logic [NW-1:0] new_node;
  logic          tail_room;

  function automatic logic [GW-1:0] gaddr(input logic [NW-1:0] n, input logic [CW-1:0] c);
    return GW'(n) * GW'(ALPHABET) + GW'(c);
  endfunction

  assign new_node  = count_r[NW-1:0];
  assign tail_room = (tail_r < KW'(NODES));

  // Status toward the controller.
  assign stat.built   = built_r;
  assign stat.ch_zero = (goto_rd_r == '0);
  assign stat.full    = (count_r >= KW'(NODES));
  assign stat.last    = last_r;
  assign stat.c_last  = (c_r == CW'(ALPHABET - 1));
  assign stat.q_more  = (head_r < tail_r);

  assign res_mask   = res_mask_r;
  assign res_node   = res_node_r;
  assign res_status = res_status_r;

  // Next-state and memory port logic for each operation.
  always_comb begin
    letter_nxt = letter_r;   last_nxt = last_r;     restart_nxt = restart_r;
    pbit_nxt = pbit_r;       tmp_nxt = tmp_r;       built_nxt = built_r;
    count_nxt = count_r;     head_nxt = head_r;     tail_nxt = tail_r;
    pos_nxt = pos_r;         scan_nxt = scan_r;     id_nxt = id_r;
    f_nxt = f_r;             cur_nxt = cur_r;       c_nxt = c_r;
    res_mask_nxt = res_mask_r; res_node_nxt = res_node_r; res_status_nxt = res_status_r;
    g_we = 1'b0; g_addr = '0; g_wd = '0;
    f_we = 1'b0; f_addr = '0; f_wd = '0;
    m_we = 1'b0; m_addr = '0; m_wd = '0;
    q_we = 1'b0; q_addr = '0; q_wd = '0;
    unique case (cmd.op)
      OP_IDLE: begin
      end
      OP_LATCH: begin
        letter_nxt  = (32'(letter) >= ALPHABET) ? CW'(ALPHABET - 1) : CW'(letter);
        last_nxt    = last_letter;
        restart_nxt = restart;
        pbit_nxt    = (32'(pattern_index) < PATTERNS) ? (PW'(1) << pattern_index) : '0;
        res_mask_nxt = '0; res_node_nxt = '0; res_status_nxt = ST_OK;
        c_nxt = '0;
      end
      OP_ROOT_CLR: begin
        g_we = 1'b1; g_addr = gaddr('0, c_r);
        f_we = 1'b1; m_we = 1'b1;
        c_nxt = stat.c_last ? '0 : c_r + 1'b1;
        count_nxt = KW'(1); pos_nxt = '0; scan_nxt = '0; built_nxt = 1'b0;
      end
      OP_INS_RD: begin
        if (built_r) begin
          res_status_nxt = ST_REJECT; res_node_nxt = pos_r;
        end else begin
          g_addr = gaddr(pos_r, letter_r);
        end
      end
      OP_INS_CHK: begin
        if (!stat.ch_zero) begin
          res_node_nxt = goto_rd_r;
          cur_nxt = goto_rd_r;
          m_addr = goto_rd_r;
          pos_nxt = last_r ? '0 : goto_rd_r;
        end else if (stat.full) begin
          res_status_nxt = ST_FULL; res_node_nxt = pos_r; pos_nxt = '0;
        end else begin
          // Allocate a fresh node and hang it under the insert position.
          count_nxt = count_r + 1'b1;
          g_we = 1'b1; g_addr = gaddr(pos_r, letter_r); g_wd = new_node;
          f_we = 1'b1; f_addr = new_node;
          m_we = 1'b1; m_addr = new_node; m_wd = last_r ? pbit_r : '0;
          res_node_nxt = new_node; cur_nxt = new_node;
          pos_nxt = last_r ? '0 : new_node;
          c_nxt = '0;
        end
      end
      OP_INS_MASK: begin
        m_we = 1'b1; m_addr = cur_r; m_wd = mask_rd_r | pbit_r;
      end
      OP_INS_ROW: begin
        g_we = 1'b1; g_addr = gaddr(cur_r, c_r);
        c_nxt = stat.c_last ? '0 : c_r + 1'b1;
      end
      OP_B_START: begin
        if (built_r) begin
          scan_nxt = '0; pos_nxt = '0;
        end else begin
          head_nxt = '0; tail_nxt = '0; c_nxt = '0;
        end
      end
      OP_B_RRD: begin
        g_addr = gaddr('0, c_r);
      end
      OP_B_RCHK: begin
        // Children of the root fail to the root.
        if (!stat.ch_zero && tail_room) begin
          f_we = 1'b1; f_addr = goto_rd_r;
          q_we = 1'b1; q_addr = tail_r[NW-1:0]; q_wd = goto_rd_r;
          tail_nxt = tail_r + 1'b1;
        end
        c_nxt = stat.c_last ? '0 : c_r + 1'b1;
      end
      OP_B_POP: begin
        if (stat.q_more) begin
          q_addr = head_r[NW-1:0]; head_nxt = head_r + 1'b1;
        end else begin
          built_nxt = 1'b1; scan_nxt = '0; pos_nxt = '0;
        end
      end
      OP_B_ID: begin
        id_nxt = queue_rd_r; f_addr = queue_rd_r;
      end
      OP_B_F: begin
        f_nxt = fail_rd_r; m_addr = fail_rd_r;
      end
      OP_B_MF: begin
        tmp_nxt = mask_rd_r; m_addr = id_r;
      end
      OP_B_MI: begin
        m_we = 1'b1; m_addr = id_r; m_wd = mask_rd_r | tmp_r; c_nxt = '0;
      end
      OP_B_E1: begin
        g_addr = gaddr(id_r, c_r);
      end
      OP_B_E2: begin
        cur_nxt = goto_rd_r; g_addr = gaddr(f_r, c_r);
      end
      OP_B_E3: begin
        // A real child gets its failure link; a missing edge borrows the failure's.
        if (cur_r != '0) begin
          f_we = 1'b1; f_addr = cur_r; f_wd = goto_rd_r;
          if (tail_room) begin
            q_we = 1'b1; q_addr = tail_r[NW-1:0]; q_wd = cur_r;
            tail_nxt = tail_r + 1'b1;
          end
        end else begin
          g_we = 1'b1; g_addr = gaddr(id_r, c_r); g_wd = goto_rd_r;
        end
        c_nxt = stat.c_last ? '0 : c_r + 1'b1;
      end
      OP_SC_RD: begin
        g_addr = gaddr(restart_r ? '0 : scan_r, letter_r);
      end
      OP_SC_CHK: begin
        scan_nxt = goto_rd_r; res_node_nxt = goto_rd_r; m_addr = goto_rd_r;
      end
      OP_SC_MK: begin
        res_mask_nxt = mask_rd_r;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= KW'(1); pos_r <= '0; scan_r <= '0; built_r <= 1'b0;
      head_r <= '0; tail_r <= '0; c_r <= '0;
    end else begin
      count_r <= count_nxt; pos_r <= pos_nxt; scan_r <= scan_nxt; built_r <= built_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt; c_r <= c_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    letter_r <= letter_nxt; last_r <= last_nxt; restart_r <= restart_nxt;
    pbit_r <= pbit_nxt; tmp_r <= tmp_nxt; id_r <= id_nxt; f_r <= f_nxt; cur_r <= cur_nxt;
    res_mask_r <= res_mask_nxt; res_node_r <= res_node_nxt; res_status_r <= res_status_nxt;
  end

  // Single-port memories with registered reads.
  always_ff @(posedge clk) begin
    if (g_we) goto_mem[g_addr] <= g_wd;
    goto_rd_r <= goto_mem[g_addr];
  end

  always_ff @(posedge clk) begin
    if (f_we) fail_mem[f_addr] <= f_wd;
    fail_rd_r <= fail_mem[f_addr];
  end

  always_ff @(posedge clk) begin
    if (m_we) mask_mem[m_addr] <= m_wd;
    mask_rd_r <= mask_mem[m_addr];
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_addr] <= q_wd;
    queue_rd_r <= queue_mem[q_addr];
  end

endmodule

FILE: hw/rtl/acm_controller.sv
// Controller of the Aho-Corasick matcher: sequences each request through the datapath.
// Depends on acm_pkg; talks to acm_datapath through dp_cmd_t and dp_stat_t.
module acm_controller import acm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] in_tuser,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CLR,
    S_INS_RD, S_INS_CHK, S_INS_MASK, S_INS_ROW,
    S_B_START, S_B_RRD, S_B_RCHK, S_B_POP, S_B_ID, S_B_F, S_B_MF, S_B_MI,
    S_B_E1, S_B_E2, S_B_E3,
    S_SC_RD, S_SC_CHK, S_SC_MK, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;

  // Next state, result flag and datapath operation.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = OP_IDLE;
    unique case (state_r)
      S_INIT: begin
        cmd.op = OP_ROOT_CLR;
        if (stat.c_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.op = OP_LATCH;
          unique case (in_tuser)
            REQ_INSERT: state_nxt = S_INS_RD;
            REQ_BUILD:  state_nxt = S_B_START;
            REQ_SCAN:   state_nxt = S_SC_RD;
            default:    state_nxt = S_CLR;
          endcase
        end
      end
      S_CLR: begin
        cmd.op = OP_ROOT_CLR;
        if (stat.c_last) state_nxt = S_DONE;
      end
      S_INS_RD: begin
        cmd.op = OP_INS_RD;
        state_nxt = stat.built ? S_DONE : S_INS_CHK;
      end
      S_INS_CHK: begin
        cmd.op = OP_INS_CHK;
        if (!stat.ch_zero) state_nxt = stat.last ? S_INS_MASK : S_DONE;
        else               state_nxt = stat.full ? S_DONE : S_INS_ROW;
      end
      S_INS_MASK: begin
        cmd.op = OP_INS_MASK;
        state_nxt = S_DONE;
      end
      S_INS_ROW: begin
        cmd.op = OP_INS_ROW;
        if (stat.c_last) state_nxt = S_DONE;
      end
      S_B_START: begin
        cmd.op = OP_B_START;
        state_nxt = stat.built ? S_DONE : S_B_RRD;
      end
      S_B_RRD: begin
        cmd.op = OP_B_RRD;
        state_nxt = S_B_RCHK;
      end
      S_B_RCHK: begin
        cmd.op = OP_B_RCHK;
        state_nxt = stat.c_last ? S_B_POP : S_B_RRD;
      end
      S_B_POP: begin
        cmd.op = OP_B_POP;
        state_nxt = stat.q_more ? S_B_ID : S_DONE;
      end
      S_B_ID: begin
        cmd.op = OP_B_ID;
        state_nxt = S_B_F;
      end
      S_B_F: begin
        cmd.op = OP_B_F;
        state_nxt = S_B_MF;
      end
      S_B_MF: begin
        cmd.op = OP_B_MF;
        state_nxt = S_B_MI;
      end
      S_B_MI: begin
        cmd.op = OP_B_MI;
        state_nxt = S_B_E1;
      end
      S_B_E1: begin
        cmd.op = OP_B_E1;
        state_nxt = S_B_E2;
      end
      S_B_E2: begin
        cmd.op = OP_B_E2;
        state_nxt = S_B_E3;
      end
      S_B_E3: begin
        cmd.op = OP_B_E3;
        state_nxt = stat.c_last ? S_B_POP : S_B_E1;
      end
      S_SC_RD: begin
        cmd.op = OP_SC_RD;
        state_nxt = S_SC_CHK;
      end
      S_SC_CHK: begin
        cmd.op = OP_SC_CHK;
        state_nxt = S_SC_MK;
      end
      S_SC_MK: begin
        cmd.op = OP_SC_MK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/aho_corasick_multi_pattern_matcher.sv
// Aho-Corasick multi-pattern matcher: one request at a time, one result per request.
// An insert that allocates a node also clears the node's goto row, one entry a cycle;
// an insert that ends a pattern on an existing node also updates that node's mask, and
// an insert after a build is rejected without touching the trie. A build walks the
// trie breadth-first through the single-port goto memory; a repeated build does no
// work. A clear rewrites the root row. A waiting result holds off the next request.
// After reset the root row is cleared, during which in_tready stays low.
// Depends on acm_pkg, acm_controller and acm_datapath.
module aho_corasick_multi_pattern_matcher import acm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // letter[4:0], pattern_index[8:5], restart[9], zero pad
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  input  logic        in_tlast,   // last_letter
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // match_mask[15:0], node[25:16], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [PATTERNS-1:0]      res_mask;
  logic [$clog2(NODES)-1:0] res_node;
  logic [1:0]               res_status;

  acm_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  acm_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .letter        (in_tdata[4:0]),
    .last_letter   (in_tlast),
    .pattern_index (in_tdata[8:5]),
    .restart       (in_tdata[9]),
    .cmd           (cmd),
    .stat          (stat),
    .res_mask      (res_mask),
    .res_node      (res_node),
    .res_status    (res_status)
  );

  // Result packing.
  assign out_tdata = {6'd0, 10'(res_node), 16'(res_mask)};
  assign out_tuser = res_status;

endmodule

FILE: hw/rtl/acm_checker.sv
// Port-level checker for the Aho-Corasick matcher, bound to the top level.
// Depends on aho_corasick_multi_pattern_matcher_macros.svh.
`include "aho_corasick_multi_pattern_matcher_macros.svh"

module acm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A waiting result holds its payload.
  `ACM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "waiting result changed")

  // Only one request is in flight: no acceptance while a result waits.
  `ACM_ASSERT_ALWAYS(a_one_in_flight, !(in_tready && out_tvalid), "ready while result waits")

  // A request never produces its result in the cycle after acceptance.
  `ACM_ASSERT_NEXT(a_no_early_result, in_tvalid && in_tready, !out_tvalid, "result too early")

  // Failed inserts carry no match bits.
  `ACM_ASSERT_ALWAYS(a_err_no_mask, !out_tvalid || out_tuser == 2'd0 || out_tdata[15:0] == 16'd0, "mask on error")

endmodule

bind aho_corasick_multi_pattern_matcher acm_checker u_acm_checker (.*);

FILE: verif/testbench.sv
// Self-checking testbench for the Aho-Corasick multi-pattern matcher.
// It holds its own model of the trie, the links and the scan state, and compares every
// result with the model. It depends on acm_pkg and aho_corasick_multi_pattern_matcher.
module testbench import acm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRIE_NODES = 1024;
  localparam int LETTERS    = 26;
  localparam int PAT_COUNT  = 16;
  localparam int IDLE_LIMIT = 400000;

  // Expected fields of one result.
  typedef struct {
    logic [15:0] mask;
    logic [9:0]  node;
    logic [1:0]  status;
  } match_result_t;

  // Automaton model and the queue of results it still expects.
  class match_scoreboard;
    int unsigned goto_next[TRIE_NODES * LETTERS];
    int unsigned fail_of[TRIE_NODES];
    logic [15:0] hit_mask[TRIE_NODES];
    int unsigned node_total;
    int unsigned ins_pos;
    int unsigned scan_pos;
    bit          linked;
    match_result_t pending[$];
    int errors;

    function new();
      foreach (goto_next[i]) goto_next[i] = 0;
      foreach (fail_of[i]) fail_of[i] = 0;
      foreach (hit_mask[i]) hit_mask[i] = '0;
      node_total = 1;
      ins_pos = 0;
      scan_pos = 0;
      linked = 0;
      errors = 0;
    endfunction

    // Breadth-first walk: failure links, merged masks and a complete goto table.
    function void link_trie();
      int unsigned walk[$];
      int unsigned id, f, ch;
      for (int c = 0; c < LETTERS; c++) begin
        ch = goto_next[c];
        if (ch != 0) begin
          fail_of[ch] = 0;
          walk.push_back(ch);
        end
      end
      while (walk.size() != 0) begin
        id = walk.pop_front();
        f = fail_of[id];
        hit_mask[id] |= hit_mask[f];
        for (int c = 0; c < LETTERS; c++) begin
          ch = goto_next[id * LETTERS + c];
          if (ch != 0) begin
            fail_of[ch] = goto_next[f * LETTERS + c];
            walk.push_back(ch);
          end else begin
            goto_next[id * LETTERS + c] = goto_next[f * LETTERS + c];
          end
        end
      end
      linked = 1;
    endfunction

    // Note one accepted request and queue the result it should cause.
    function void note_request(logic [1:0] kind, logic [4:0] letter, logic last,
                               logic [3:0] pat, logic restart);
      match_result_t r;
      int unsigned c, ch, pos;
      c = (letter >= LETTERS) ? LETTERS - 1 : letter;
      r.mask = '0;
      r.node = '0;
      r.status = ST_OK;
      case (kind)
        REQ_INSERT: begin
          pos = ins_pos;
          r.node = 10'(pos);
          if (linked) begin
            r.status = ST_REJECT;
          end else begin
            ch = goto_next[pos * LETTERS + c];
            if (ch == 0) begin
              if (node_total >= TRIE_NODES) begin
                r.status = ST_FULL;
                ins_pos = 0;
              end else begin
                ch = node_total;
                node_total++;
                for (int k = 0; k < LETTERS; k++) goto_next[ch * LETTERS + k] = 0;
                hit_mask[ch] = '0;
                fail_of[ch] = 0;
                goto_next[pos * LETTERS + c] = ch;
              end
            end
            if (r.status == ST_OK) begin
              r.node = 10'(ch);
              if (last) begin
                if (pat < PAT_COUNT) hit_mask[ch][pat] = 1'b1;
                ins_pos = 0;
              end else begin
                ins_pos = ch;
              end
            end
          end
        end
        REQ_BUILD: begin
          if (!linked) link_trie();
          scan_pos = 0;
          ins_pos = 0;
        end
        REQ_SCAN: begin
          pos = restart ? 0 : scan_pos;
          scan_pos = goto_next[pos * LETTERS + c];
          r.node = 10'(scan_pos);
          r.mask = hit_mask[scan_pos];
        end
        default: begin
          for (int k = 0; k < LETTERS; k++) goto_next[k] = 0;
          hit_mask[0] = '0;
          fail_of[0] = 0;
          node_total = 1;
          ins_pos = 0;
          scan_pos = 0;
          linked = 0;
        end
      endcase
      pending.push_back(r);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(logic [15:0] mask, logic [9:0] node, logic [1:0] status);
      match_result_t r;
      if (pending.size() == 0) begin
        $error("Result with no request outstanding: mask %h node %0d status %0d",
               mask, node, status);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (mask !== r.mask) begin
        $error("match_mask: expected %h, actual %h", r.mask, mask);
        errors++;
      end
      if (node !== r.node) begin
        $error("node: expected %0d, actual %0d", r.node, node);
        errors++;
      end
      if (status !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // letter[4:0], pattern_index[8:5], restart[9], zero pad
  logic [1:0]  in_tuser = REQ_INSERT;  // req_type[1:0]
  logic        in_tlast = 1'b0; // last_letter
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // match_mask[15:0], node[25:16], zero pad
  logic [1:0]  out_tuser;       // status[1:0]

  match_scoreboard sb = new();
  int tx_idle_pct = 18;
  int rx_idle_pct = 79;
  int rx_hold_cycles = 0;
  int quiet_cycles = 0;
  int items_sent = 0;

  aho_corasick_multi_pattern_matcher DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off counted down here.
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles <= rx_hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor and watchdog on the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_request(in_tuser, in_tdata[4:0], in_tlast, in_tdata[8:5], in_tdata[9]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[15:0], out_tdata[25:16], out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offer one request; called and returning at a falling edge.
  task automatic send_request(logic [1:0] kind, logic [4:0] letter, logic last,
                              logic [3:0] pat, logic restart);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {6'b0, restart, pat, letter};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Insert one pattern of the given length, mostly from a small letter set.
  task automatic insert_pattern(int len, int base, int span);
    logic [4:0] lt;
    for (int i = 0; i < len; i++) begin
      lt = ($urandom_range(19) == 0) ? 5'($urandom_range(31)) : 5'(base + $urandom_range(span));
      send_request(REQ_INSERT, lt, i == len - 1, 4'($urandom_range(15)),
                   1'($urandom_range(1)));
    end
  endtask

  // One trie: clear, a few patterns, maybe some noise, a build and a run of scans mixed with rare inserts and builds.
  task automatic trie_episode();
    int base, span, pats, scans;
    logic [4:0] lt;
    span = $urandom_range(3, 1);
    base = $urandom_range(LETTERS - 1 - span);
    pats = $urandom_range(6, 1);
    scans = $urandom_range(80, 30);
    send_request(REQ_CLEAR, 5'($urandom_range(31)), 1'($urandom_range(1)),
                 4'($urandom_range(15)), 1'($urandom_range(1)));
    for (int p = 0; p < pats; p++) insert_pattern($urandom_range(6, 1), base, span);
    if ($urandom_range(3) == 0)
      send_request(REQ_SCAN, 5'(base), 1'b0, 4'($urandom_range(15)), 1'b1);
    send_request(REQ_BUILD, 5'($urandom_range(31)), 1'($urandom_range(1)),
                 4'($urandom_range(15)), 1'($urandom_range(1)));
    for (int s = 0; s < scans; s++) begin
      lt = ($urandom_range(24) == 0) ? 5'($urandom_range(31)) : 5'(base + $urandom_range(span));
      case ($urandom_range(39))
        0: send_request(REQ_INSERT, lt, 1'($urandom_range(1)), 4'($urandom_range(15)), 1'b0);
        1: send_request(REQ_BUILD, lt, 1'b0, 4'($urandom_range(15)), 1'b0);
        default: send_request(REQ_SCAN, lt, 1'($urandom_range(1)), 4'($urandom_range(15)),
                              $urandom_range(15) == 0);
      endcase
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: patterns "ab", "b", "b" then a saturated letter, and "z"; scans before and
    // after the build, a repeated build, an insert after the build, and a clear.
    send_request(REQ_INSERT, 5'd0, 1'b0, 4'd0, 1'b0);
    send_request(REQ_INSERT, 5'd1, 1'b1, 4'd0, 1'b0);
    send_request(REQ_INSERT, 5'd1, 1'b1, 4'd15, 1'b1);
    send_request(REQ_INSERT, 5'd1, 1'b0, 4'd3, 1'b0);
    send_request(REQ_INSERT, 5'd31, 1'b1, 4'd7, 1'b0);
    send_request(REQ_INSERT, 5'd25, 1'b1, 4'd9, 1'b0);
    send_request(REQ_SCAN, 5'd0, 1'b0, 4'd0, 1'b0);
    send_request(REQ_SCAN, 5'd2, 1'b0, 4'd0, 1'b0);
    send_request(REQ_BUILD, 5'd0, 1'b0, 4'd0, 1'b0);
    send_request(REQ_BUILD, 5'd31, 1'b1, 4'd15, 1'b1);
    send_request(REQ_INSERT, 5'd3, 1'b1, 4'd1, 1'b0);
    send_request(REQ_SCAN, 5'd0, 1'b0, 4'd0, 1'b1);
    send_request(REQ_SCAN, 5'd1, 1'b0, 4'd0, 1'b0);
    send_request(REQ_SCAN, 5'd1, 1'b0, 4'd0, 1'b0);
    send_request(REQ_SCAN, 5'd30, 1'b0, 4'd0, 1'b0);
    send_request(REQ_SCAN, 5'd0, 1'b0, 4'd0, 1'b1);
    send_request(REQ_CLEAR, 5'd0, 1'b0, 4'd0, 1'b0);
    send_request(REQ_SCAN, 5'd0, 1'b0, 4'd0, 1'b0);

    // Fill the node table with one long chain, then overflow it.
    for (int i = 1; i < TRIE_NODES; i++)
      send_request(REQ_INSERT, 5'(i % LETTERS), 1'b0, 4'd0, 1'b0);
    send_request(REQ_INSERT, 5'd7, 1'b0, 4'd0, 1'b0);
    send_request(REQ_INSERT, 5'd1, 1'b1, 4'd4, 1'b0);
    send_request(REQ_CLEAR, 5'd0, 1'b0, 4'd0, 1'b0);

    // Random tries under three idling phases.
    while (items_sent < 1350) trie_episode();
    wait_drained();
    tx_idle_pct = 79;
    rx_idle_pct = 18;
    while (items_sent < 1700) trie_episode();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_cycles = 3000;
    while (items_sent < 2000) trie_episode();

    wait_drained();
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/acm_pkg.sv
hw/rtl/acm_datapath.sv
hw/rtl/acm_controller.sv
hw/rtl/aho_corasick_multi_pattern_matcher.sv
hw/rtl/acm_checker.sv
verif/testbench.sv
